/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lag1ac_pkg.sv */
// constants and widths for the lag-1 autocorrelation block
`timescale 1ns / 1ps
package lag1ac_pkg;
  localparam int MaxSamples = 4096;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CountW     = AddrW + 1;
  localparam int SampleW    = 32;
  localparam int SumW       = SampleW + AddrW + 1;
  localparam int MeanW      = SampleW + 16;
  localparam int DvdW       = SumW + 16;
  localparam int HalfW      = MeanW / 2;
  localparam int ProdW      = 2 * MeanW;
  localparam int AccW       = ProdW + AddrW + 2;
  localparam int CoefW      = 32;
  localparam int MinW       = 13;
  localparam int CapW       = 12;
  localparam int RecipTen   = 6554;

  localparam logic [MinW-1:0] MinReset = 13'd50;
  localparam logic [CapW-1:0] CapReset = 12'd100;

  localparam logic RegMinSamples = 1'b0;
  localparam logic RegBurnInCap  = 1'b1;
endpackage

/* design/lag1_autocorrelation.sv */
// lag-1 autocorrelation over a stored series of unsigned 32-bit integer samples
// load: one beat per cycle; the beat with tlast starts the evaluation
// evaluation after tlast: summing of samples b..n-1, the mean divider,
// a 24x24 partial-product pass per sample, the final quotient, then
// handing over the result; b = min(burn_in_cap, n/10)
// reset: counters and flags cleared, registers to 50 and 100, no clear pass
`timescale 1ns / 1ps
module lag1_autocorrelation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // coefficient
  output logic [1:0]  m_axis_tuser    // degenerate, overflowed
);
  localparam logic [3:0] StLoad = 4'd0, StChk = 4'd1, StSum = 4'd2, StMdiv = 4'd3,
                         StDrd = 4'd4, StDdev = 4'd5, StMul = 4'd6, StAcc = 4'd7,
                         StQini = 4'd8, StQdiv = 4'd9, StDone = 4'd10;
  localparam int AW = lag1ac_pkg::AddrW;
  localparam int CW = lag1ac_pkg::CountW;

  logic [3:0] state_q;
  logic [lag1ac_pkg::MinW-1:0] min_q;
  logic [lag1ac_pkg::CapW-1:0] cap_q;
  logic [CW-1:0] count_q, n_q, ptr_q, start_q, c_q;
  logic ovf_q, rv_q, neg_q, dneg_q, pneg_q;
  logic [lag1ac_pkg::SampleW-1:0] mem [lag1ac_pkg::MaxSamples];
  logic [lag1ac_pkg::SampleW-1:0] rdata_q;
  logic [lag1ac_pkg::SumW-1:0] sum_q;
  logic [lag1ac_pkg::DvdW-1:0] dvd_q;
  logic [CW:0] rem_q;
  logic [6:0] it_q;
  logic [lag1ac_pkg::MeanW-1:0] mean_q, dcur_q, dprev_q;
  logic [2:0] ph_q;
  logic [lag1ac_pkg::MeanW-1:0] pps_q, ppx_q;
  logic [lag1ac_pkg::ProdW-1:0] psq_q, px_q;
  logic signed [lag1ac_pkg::AccW-1:0] num_q;
  logic [lag1ac_pkg::AccW-1:0] den_q;
  logic [lag1ac_pkg::AccW:0] qmag_q;
  logic [lag1ac_pkg::CoefW-1:0] q_q;
  logic [lag1ac_pkg::CoefW-1:0] out_coef_q;
  logic res_deg_q, res_ovf_q, out_deg_q, out_ovf_q, out_valid_q;

  logic wr_en, in_acc, stored;
  logic [CW+16:0] tenth_full;
  logic [CW-1:0] tenth, start_c;
  logic [CW:0] r2;
  logic [lag1ac_pkg::MeanW-1:0] vsh, dmag;
  logic [lag1ac_pkg::HalfW-1:0] a_sel, bs_sel, bx_sel;
  logic [6:0] shamt;
  logic [lag1ac_pkg::AccW:0] qt;
  logic [lag1ac_pkg::CoefW:0] qr;
  logic [lag1ac_pkg::CoefW-1:0] coef_c;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == lag1ac_pkg::RegBurnInCap) ? {20'd0, cap_q} : {19'd0, min_q};

  assign s_axis_tready = (state_q == StLoad);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign stored = (count_q < CW'(lag1ac_pkg::MaxSamples));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_coef_q;
  assign m_axis_tuser  = {out_ovf_q, out_deg_q};

  assign tenth_full = n_q * 17'(lag1ac_pkg::RecipTen);
  assign tenth      = tenth_full[CW+15:16];
  assign start_c    = ({1'b0, cap_q} < tenth) ? {1'b0, cap_q} : tenth;
  assign r2         = {rem_q[CW-1:0], dvd_q[lag1ac_pkg::DvdW-1]};

  assign vsh  = {rdata_q, 16'd0};
  assign dmag = (vsh < mean_q) ? (mean_q - vsh) : (vsh - mean_q);

  assign a_sel  = ph_q[2] ? dcur_q[lag1ac_pkg::MeanW-1:lag1ac_pkg::HalfW]
                          : dcur_q[lag1ac_pkg::HalfW-1:0];
  assign bs_sel = ph_q[1] ? dcur_q[lag1ac_pkg::MeanW-1:lag1ac_pkg::HalfW]
                          : dcur_q[lag1ac_pkg::HalfW-1:0];
  assign bx_sel = ph_q[1] ? dprev_q[lag1ac_pkg::MeanW-1:lag1ac_pkg::HalfW]
                          : dprev_q[lag1ac_pkg::HalfW-1:0];
  assign shamt  = 7'((32'(ph_q[2]) + 32'(ph_q[1])) * lag1ac_pkg::HalfW);

  assign qt = (it_q == 7'd0) ? qmag_q : {qmag_q[lag1ac_pkg::AccW-1:0], 1'b0};
  assign qr = {1'b0, q_q} + 33'd1;

  // rounded quotient with sign, zero for a degenerate series
  assign coef_c = res_deg_q ? '0 :
                  (neg_q ? (32'd0 - qr[lag1ac_pkg::CoefW:1]) : qr[lag1ac_pkg::CoefW:1]);

  always_ff @(posedge clk_i) begin
    if (in_acc && stored) begin
      mem[count_q[AW-1:0]] <= s_axis_tdata;
    end
    rdata_q <= mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= lag1ac_pkg::MinReset;
      cap_q <= lag1ac_pkg::CapReset;
    end else if (wr_en) begin
      if (paddr[2] == lag1ac_pkg::RegMinSamples) begin
        min_q <= pwdata[lag1ac_pkg::MinW-1:0];
      end else begin
        cap_q <= pwdata[lag1ac_pkg::CapW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && (!out_valid_q || m_axis_tready)) begin
      out_coef_q <= coef_c;
      out_deg_q  <= res_deg_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      ovf_q   <= 1'b0;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (stored) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              state_q <= StChk;
            end
          end
        end
        StChk: begin
          ptr_q <= start_c;
          rv_q  <= 1'b0;
          if (n_q < CW'(min_q) || n_q == '0) begin
            state_q <= StDone;
          end else begin
            state_q <= StSum;
          end
        end
        StSum: begin
          if (ptr_q < n_q) begin
            ptr_q <= ptr_q + CW'(1);
            rv_q  <= 1'b1;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              state_q <= StMdiv;
            end
          end
        end
        StMdiv: begin
          ptr_q <= start_q;
          if (it_q == 7'(lag1ac_pkg::DvdW - 1)) begin
            state_q <= StDrd;
          end
        end
        StDrd:  state_q <= StDdev;
        StDdev: state_q <= StMul;
        StMul: begin
          if (ph_q == 3'd7) begin
            state_q <= StAcc;
          end
        end
        StAcc: begin
          ptr_q <= ptr_q + CW'(1);
          if (ptr_q + CW'(1) == n_q) begin
            state_q <= StQini;
          end else begin
            state_q <= StDrd;
          end
        end
        StQini: begin
          if (den_q == '0) begin
            state_q <= StDone;
          end else begin
            state_q <= StQdiv;
          end
        end
        StQdiv: begin
          if (it_q == 7'(lag1ac_pkg::CoefW - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= StLoad;
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StLoad: begin
        n_q       <= count_q + (stored ? CW'(1) : CW'(0));
        res_ovf_q <= ovf_q || !stored;
        res_deg_q <= 1'b1;
      end
      StChk: begin
        start_q <= start_c;
        c_q     <= n_q - start_c;
        sum_q   <= '0;
      end
      StSum: begin
        if (rv_q) begin
          sum_q <= sum_q + lag1ac_pkg::SumW'(rdata_q);
        end
        dvd_q  <= {sum_q, 16'd0} + lag1ac_pkg::DvdW'(c_q >> 1);
        rem_q  <= '0;
        it_q   <= '0;
        mean_q <= '0;
        num_q  <= '0;
        den_q  <= '0;
      end
      StMdiv: begin
        dvd_q <= {dvd_q[lag1ac_pkg::DvdW-2:0], 1'b0};
        it_q  <= it_q + 7'd1;
        if (r2 >= {1'b0, c_q}) begin
          rem_q  <= r2 - {1'b0, c_q};
          mean_q <= {mean_q[lag1ac_pkg::MeanW-2:0], 1'b1};
        end else begin
          rem_q  <= r2;
          mean_q <= {mean_q[lag1ac_pkg::MeanW-2:0], 1'b0};
        end
      end
      StDdev: begin
        dcur_q <= dmag;
        dneg_q <= (vsh < mean_q);
        ph_q   <= '0;
        psq_q  <= '0;
        px_q   <= '0;
      end
      StMul: begin
        ph_q <= ph_q + 3'd1;
        if (!ph_q[0]) begin
          pps_q <= a_sel * bs_sel;
          ppx_q <= a_sel * bx_sel;
        end else begin
          psq_q <= psq_q + (lag1ac_pkg::ProdW'(pps_q) << shamt);
          px_q  <= px_q + (lag1ac_pkg::ProdW'(ppx_q) << shamt);
        end
      end
      StAcc: begin
        den_q   <= den_q + lag1ac_pkg::AccW'(psq_q);
        dprev_q <= dcur_q;
        pneg_q  <= dneg_q;
        if (ptr_q > start_q) begin
          if (dneg_q != pneg_q) begin
            num_q <= num_q - $signed({{(lag1ac_pkg::AccW-lag1ac_pkg::ProdW){1'b0}}, px_q});
          end else begin
            num_q <= num_q + $signed({{(lag1ac_pkg::AccW-lag1ac_pkg::ProdW){1'b0}}, px_q});
          end
        end
      end
      StQini: begin
        neg_q  <= num_q[lag1ac_pkg::AccW-1];
        qmag_q <= {1'b0, num_q[lag1ac_pkg::AccW-1] ? lag1ac_pkg::AccW'(-num_q)
                                                   : lag1ac_pkg::AccW'(num_q)};
        q_q    <= '0;
        it_q   <= '0;
      end
      StQdiv: begin
        it_q <= it_q + 7'd1;
        if (qt >= {1'b0, den_q}) begin
          qmag_q <= qt - {1'b0, den_q};
          q_q    <= {q_q[lag1ac_pkg::CoefW-2:0], 1'b1};
        end else begin
          qmag_q <= qt;
          q_q    <= {q_q[lag1ac_pkg::CoefW-2:0], 1'b0};
        end
        if (it_q == 7'(lag1ac_pkg::CoefW - 1)) begin
          res_deg_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

/* design/lag1ac_checker.sv */
// port-level checker for the lag-1 autocorrelation block
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lag1ac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  `ASSERT_CLK(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result beat dropped while stalled")
  `ASSERT_CLK(out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")
  `ASSERT_CLK(busy_after_last, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "input taken during evaluation")
  `ASSERT_CLK(deg_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0, "degenerate result not zero")
endmodule

bind lag1_autocorrelation lag1ac_checker u_lag1ac_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);

/* tb/sv/lag1_autocorrelation_test.sv */
// testbench for the lag-1 autocorrelation block: directed table, random series, predictor check
`timescale 1ns / 1ps
module lag1_autocorrelation_test;
  typedef struct packed {
    logic [31:0] coef;
    logic        degen;
    logic        ovf;
  } corr_t;

  typedef enum logic [1:0] {RowBeat, RowMin, RowCap} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] data;
    logic        last;
    logic        typed;
    corr_t       res;
  } row_t;

  localparam int IdleLimit = 200000;
  localparam int RandomItems = 750;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // sample
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // coefficient
  logic [1:0]  m_axis_tuser;         // degenerate, overflowed

  lag1_autocorrelation i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]    series_store [lag1ac_pkg::MaxSamples];
  int unsigned    series_len;
  logic           series_dropped;
  logic [lag1ac_pkg::MinW-1:0] min_count;
  logic [lag1ac_pkg::CapW-1:0] burn_cap;
  corr_t          corr_q [$];
  int             errors;
  bit             quiet;
  int             stall_left;
  int             idle_cycles;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic corr_t series_corr();
    corr_t                r;
    int unsigned          start, cnt;
    logic [63:0]          total, mean;
    logic signed [127:0]  num, den, dcur, dprev;
    logic [127:0]         mag;
    logic [159:0]         q;
    logic                 neg;
    r = '{coef: '0, degen: 1'b1, ovf: series_dropped};
    if (series_len < min_count || series_len == 0) return r;
    start = series_len / 10;
    if (burn_cap < start) start = burn_cap;
    cnt = series_len - start;
    total = '0;
    for (int i = start; i < series_len; i++) total += series_store[i];
    mean = ((total << 16) + cnt / 2) / cnt;
    num = '0;
    den = '0;
    dprev = '0;
    for (int i = start; i < series_len; i++) begin
      dcur = $signed({64'd0, series_store[i], 16'd0}) - $signed({64'd0, mean});
      den += dcur * dcur;
      if (i > start) num += dcur * dprev;
      dprev = dcur;
    end
    if (den == 0) return r;
    neg = num < 0;
    mag = neg ? -num : num;
    q = {mag, 31'd0} / {32'd0, den};
    q = (q + 1) >> 1;
    r.coef = neg ? -q[31:0] : q[31:0];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic push_beat(input logic [31:0] data, input logic last,
                           input logic typed, input corr_t typed_res);
    corr_t r;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (series_len < lag1ac_pkg::MaxSamples) begin
      series_store[series_len] = data;
      series_len++;
    end else begin
      series_dropped = 1'b1;
    end
    if (last) begin
      r = typed ? typed_res : series_corr();
      corr_q.insert(corr_q.size(), r);
      series_len = 0;
      series_dropped = 1'b0;
    end
  endtask

  task automatic reg_write(input row_kind_e which, input logic [31:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (corr_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= (which == RowMin) ? {lag1ac_pkg::RegMinSamples, 2'b00}
                                 : {lag1ac_pkg::RegBurnInCap, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (which == RowMin) min_count = value[lag1ac_pkg::MinW-1:0];
    else burn_cap = value[lag1ac_pkg::CapW-1:0];
  endtask

  task automatic send_series(input int len, input int shape);
    logic [31:0] v, base;
    base = $urandom();
    v = base;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = $urandom();
        1: v = base + $urandom_range(0, 15);
        2: v = v + $urandom_range(0, 2000) - 1000;
        default: v = (i % 2) ? base : base + $urandom_range(1, 1 << 20);
      endcase
      push_beat(v, i == len - 1, 1'b0, '0);
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    corr_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (corr_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 32'd0);
      end else begin
        want = corr_q.pop_front();
        if (m_axis_tdata !== want.coef) report_mismatch("coefficient", m_axis_tdata, want.coef);
        if (m_axis_tuser[0] !== want.degen)
          report_mismatch("degenerate", m_axis_tuser[0], want.degen);
        if (m_axis_tuser[1] !== want.ovf)
          report_mismatch("overflowed", m_axis_tuser[1], want.ovf);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t rows [$];
    int   sent;
    int   nser;
    errors = 0;
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    series_len = 0;
    series_dropped = 1'b0;
    min_count = lag1ac_pkg::MinReset;
    burn_cap = lag1ac_pkg::CapReset;

    // too few samples under the reset register values
    rows.insert(rows.size(), '{RowBeat, 32'h0000_0000, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b0}});
    rows.insert(rows.size(), '{RowBeat, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b0}});
    rows.insert(rows.size(), '{RowMin, 32'd2, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), '{RowCap, 32'd0, 1'b0, 1'b0, '0});
    // two extremes give exactly minus one half
    rows.insert(rows.size(), '{RowBeat, 32'h0000_0000, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), '{RowBeat, 32'hFFFF_FFFF, 1'b1, 1'b1,
                               '{32'hE000_0000, 1'b0, 1'b0}});
    // zero variance
    rows.insert(rows.size(), '{RowBeat, 32'd7, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), '{RowBeat, 32'd7, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), '{RowBeat, 32'd7, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b0}});
    for (int i = 1; i <= 4; i++) rows.insert(rows.size(), '{RowBeat, i, i == 4, 1'b0, '0});
    for (int i = 0; i < 4; i++)
      rows.insert(rows.size(), '{RowBeat, (i % 2) ? 32'hFFFF_FFFF : 32'd0, i == 3, 1'b0, '0});
    rows.insert(rows.size(), '{RowCap, 32'd4095, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), '{RowMin, 32'd4, 1'b0, 1'b0, '0});
    for (int i = 0; i < 6; i++)
      rows.insert(rows.size(), '{RowBeat, 32'h8000_0000 + i * i * 32'h1_0000, i == 5, 1'b0,
                                 '0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == RowBeat) push_beat(rows[i].data, rows[i].last, rows[i].typed,
                                             rows[i].res);
      else reg_write(rows[i].kind, rows[i].data);
    end

    // full store with the dropped sample carrying last, largest registers
    reg_write(RowMin, 32'd4096);
    reg_write(RowCap, 32'd4095);
    send_series(lag1ac_pkg::MaxSamples + 1, 0);
    reg_write(RowMin, 32'd8191);
    send_series(3, 0);

    sent = 0;
    nser = 0;
    while (sent < RandomItems) begin
      int len;
      if (nser % 5 == 0) begin
        reg_write(RowMin, ($urandom_range(0, 5) == 0) ? 32'd50 : $urandom_range(2, 20));
        reg_write(RowCap, ($urandom_range(0, 4) == 0) ? 32'd4095 : $urandom_range(0, 6));
      end
      if (sent > RandomItems - 120) quiet = 1'b1;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 40);
      send_series(len, $urandom_range(0, 3));
      sent += len;
      nser++;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (corr_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
